### src/timed_event_queue_top_defines.svh
// Assertion macros used by the timed event queue top module.
`ifndef TIMED_EVENT_QUEUE_TOP_DEFINES_SVH
`define TIMED_EVENT_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TEQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("timed event queue assertion failed");
`define TEQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("timed event queue assertion failed");
`else
`define TEQ_ASSERT(label, clk, rst, prop)
`define TEQ_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

### src/teq_pkg.sv
package teq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PEND_DEPTH  = 16;
   localparam int HANDLE_BITS = 16;

   localparam int KIND_W   = 2;
   localparam int TIME_W   = 31;
   localparam int NODE_W   = 10;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 3;
   localparam int QOUT_W   = 7;
   localparam int TOTAL_W  = 32;
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int PCNT_W   = $clog2(PEND_DEPTH + 1);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef logic [TIME_W-1:0]      time_type;
   typedef logic [NODE_W-1:0]      node_type;
   typedef logic [HANDLE_BITS-1:0] handle_type;
   typedef logic [TAG_W-1:0]       tag_type;
   typedef logic [QCNT_W-1:0]      qcnt_type;
   typedef logic [PCNT_W-1:0]      pcnt_type;
   typedef logic [QOUT_W-1:0]      qout_type;
   typedef logic [TOTAL_W-1:0]     total_type;
   typedef logic [QUEUE_DEPTH-1:0] qvec_type;
   typedef logic [PEND_DEPTH-1:0]  pvec_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [CSR_ADDR_W-1:0]  csr_addr_type;
   typedef logic [CSR_ADDR_W-3:0]  csr_index_type;

   localparam csr_index_type REG_TIME_LIMIT = '0;
   localparam time_type TIME_LIMIT_RESET = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT  = 2'd0,
      KIND_POP     = 2'd1,
      KIND_PEND    = 2'd2,
      KIND_UPGRADE = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_EMPTY   = 3'd1,
      STATUS_FULL    = 3'd2,
      STATUS_NOMATCH = 3'd3,
      STATUS_STOP    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_APPEND = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef struct packed {
      time_type   ev_time;
      node_type   node;
      handle_type handle;
      logic       prio;
   } entry_type;

   typedef struct packed {
      cmd_type   cmd;
      logic      load_flags;
      logic      low_only;
      time_type  key_time;
      node_type  key_node;
      entry_type new_entry;
   } cell_ctl_type;

   typedef struct packed {
      logic         psel;
      logic         penable;
      logic         pwrite;
      csr_addr_type paddr;
      csr_data_type pwdata;
   } apb_req_type;

endpackage

### src/teq_req_if.sv
interface teq_req_if;
   logic                        valid;
   logic                        ready;
   logic [teq_pkg::KIND_W-1:0]  kind;
   logic [teq_pkg::TIME_W-1:0]  event_time;
   logic [teq_pkg::NODE_W-1:0]  node_id;
   logic [teq_pkg::TAG_W-1:0]   handle_tag;
   logic                        hi_prio;

   modport source (
      output valid, kind, event_time, node_id, handle_tag, hi_prio,
      input  ready
   );
   modport sink (
      input  valid, kind, event_time, node_id, handle_tag, hi_prio,
      output ready
   );
endinterface

### src/teq_rsp_if.sv
interface teq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [teq_pkg::STATUS_W-1:0]  status;
   logic [teq_pkg::TIME_W-1:0]    out_time;
   logic [teq_pkg::NODE_W-1:0]    out_node;
   logic [teq_pkg::TAG_W-1:0]     out_handle;
   logic                          out_priority;
   logic [teq_pkg::QOUT_W-1:0]    queue_count;
   logic [teq_pkg::TOTAL_W-1:0]   executed_total;

   modport source (
      output valid, status, out_time, out_node, out_handle, out_priority,
             queue_count, executed_total,
      input  ready
   );
   modport sink (
      input  valid, status, out_time, out_node, out_handle, out_priority,
             queue_count, executed_total,
      output ready
   );
endinterface

### src/timed_event_queue_top.sv
// Timed event queue: a time-ordered event list held in a row of cells.
// The request channel carries one operation per transfer: insert, pop,
// pend by node, or upgrade of a pended event. Every request yields exactly
// one transfer on the response channel with a status, the popped event
// (zero unless a pop found an event), the main queue count and the
// executed event total.
// The request is registered at the accepting edge, where every cell also
// compares its entry with the request and keeps the result. The row then
// shifts in one step at the commit edge, once the response register is
// free, and the response is registered at that edge. A new request is
// taken only after the last one has been applied.
// The time limit register sits at byte address 0 of the APB-style port.
// Reset empties both the main queue and the pend list, clears current time
// and the executed total, and sets the time limit to its maximum.
// When the receiver stalls, the response register holds its result; one
// more request is still taken and waits in its apply cycle until the
// response register frees.
`include "timed_event_queue_top_defines.svh"

module timed_event_queue_top (
   input  logic                  clock,
   input  logic                  reset,
   teq_req_if.sink               req_ch,
   teq_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  teq_pkg::csr_addr_type csr_paddr,
   input  teq_pkg::csr_data_type csr_pwdata,
   output teq_pkg::csr_data_type csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [1:0] {
      STATE_IDLE  = 2'b01,
      STATE_APPLY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   teq_pkg::apb_req_type apb;
   teq_pkg::time_type    time_limit;

   logic [teq_pkg::KIND_W-1:0] item_kind_ff;
   teq_pkg::time_type          item_time_ff;
   teq_pkg::node_type          item_node_ff;
   teq_pkg::handle_type        item_handle_ff;
   logic                       item_prio_ff;

   teq_pkg::qcnt_type  event_count_ff, event_count_in;
   teq_pkg::pcnt_type  pend_count_ff, pend_count_in;
   teq_pkg::time_type  current_time_ff, current_time_in;
   teq_pkg::total_type executed_ff, executed_in;

   logic                rsp_valid_ff, rsp_valid_in;
   teq_pkg::status_type rsp_status_ff;
   teq_pkg::entry_type  rsp_entry_ff;
   teq_pkg::qcnt_type   rsp_count_ff;
   teq_pkg::total_type  rsp_total_ff;

   teq_pkg::status_type status_in;
   teq_pkg::entry_type  shown_in;

   logic accept, commit;

   teq_pkg::cell_ctl_type q_ctl, p_ctl;
   teq_pkg::cmd_type      q_cmd, p_cmd;
   teq_pkg::entry_type    q_new, p_new;

   teq_pkg::entry_type q_entry [teq_pkg::QUEUE_DEPTH];
   teq_pkg::entry_type p_entry [teq_pkg::PEND_DEPTH];
   teq_pkg::qvec_type  q_occ, q_gt, q_match, q_dec, q_first, q_below, q_remove;
   teq_pkg::pvec_type  p_occ, p_gt, p_match, p_dec, p_first, p_below;
   teq_pkg::entry_type q_pick, p_pick;
   logic               q_full, p_full, pop_all;

   assign apb.psel    = csr_psel;
   assign apb.penable = csr_penable;
   assign apb.pwrite  = csr_pwrite;
   assign apb.paddr   = csr_paddr;
   assign apb.pwdata  = csr_pwdata;

   teq_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .apb        (apb),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .time_limit (time_limit)
   );

   assign req_ch.ready = state_ff == STATE_IDLE;
   assign accept       = req_ch.valid && req_ch.ready;
   assign commit       = (state_ff == STATE_APPLY) && (!rsp_valid_ff || rsp_ch.ready);

   assign q_ctl.cmd        = q_cmd;
   assign q_ctl.load_flags = accept;
   assign q_ctl.low_only   = 1'b1;
   assign q_ctl.key_time   = req_ch.event_time;
   assign q_ctl.key_node   = req_ch.node_id;
   assign q_ctl.new_entry  = q_new;

   assign p_ctl.cmd        = p_cmd;
   assign p_ctl.load_flags = accept;
   assign p_ctl.low_only   = 1'b0;
   assign p_ctl.key_time   = req_ch.event_time;
   assign p_ctl.key_node   = req_ch.node_id;
   assign p_ctl.new_entry  = p_new;

   assign q_remove = pop_all ? '1 : ~q_below;

   for (genvar i = 0; i < teq_pkg::QUEUE_DEPTH; i++) begin : g_qcell
      logic               occ_left, gt_left;
      teq_pkg::entry_type left_entry, right_entry;

      assign q_occ[i] = teq_pkg::qcnt_type'(i) < event_count_ff;
      if (i == 0) begin : g_head
         assign occ_left   = 1'b1;
         assign gt_left    = 1'b0;
         assign left_entry = q_entry[i];
      end else begin : g_body
         assign occ_left   = q_occ[i-1];
         assign gt_left    = q_gt[i-1];
         assign left_entry = q_entry[i-1];
      end
      if (i == teq_pkg::QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = q_entry[i];
      end else begin : g_mid
         assign right_entry = q_entry[i+1];
      end

      teq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (q_ctl),
         .occ         (q_occ[i]),
         .occ_left    (occ_left),
         .gt_left     (gt_left),
         .remove_here (q_remove[i]),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (q_entry[i]),
         .gt          (q_gt[i]),
         .match       (q_match[i])
      );
   end

   for (genvar i = 0; i < teq_pkg::PEND_DEPTH; i++) begin : g_pcell
      logic               occ_left, gt_left;
      teq_pkg::entry_type left_entry, right_entry;

      assign p_occ[i] = teq_pkg::pcnt_type'(i) < pend_count_ff;
      if (i == 0) begin : g_head
         assign occ_left   = 1'b1;
         assign gt_left    = 1'b0;
         assign left_entry = p_entry[i];
      end else begin : g_body
         assign occ_left   = p_occ[i-1];
         assign gt_left    = p_gt[i-1];
         assign left_entry = p_entry[i-1];
      end
      if (i == teq_pkg::PEND_DEPTH - 1) begin : g_tail
         assign right_entry = p_entry[i];
      end else begin : g_mid
         assign right_entry = p_entry[i+1];
      end

      teq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (p_ctl),
         .occ         (p_occ[i]),
         .occ_left    (occ_left),
         .gt_left     (gt_left),
         .remove_here (~p_below[i]),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (p_entry[i]),
         .gt          (p_gt[i]),
         .match       (p_match[i])
      );
   end

   // The first matching cell and every cell behind it close the gap on removal.
   assign q_dec   = q_match - teq_pkg::qvec_type'(1);
   assign q_first = q_match & ~q_dec;
   assign q_below = q_dec & ~q_match;
   assign p_dec   = p_match - teq_pkg::pvec_type'(1);
   assign p_first = p_match & ~p_dec;
   assign p_below = p_dec & ~p_match;

   always_comb begin
      q_pick = '0;
      for (int i = 0; i < teq_pkg::QUEUE_DEPTH; i++) begin
         if (q_first[i]) begin
            q_pick = q_pick | q_entry[i];
         end
      end
   end

   always_comb begin
      p_pick = '0;
      for (int i = 0; i < teq_pkg::PEND_DEPTH; i++) begin
         if (p_first[i]) begin
            p_pick = p_pick | p_entry[i];
         end
      end
   end

   assign q_full = event_count_ff == teq_pkg::qcnt_type'(teq_pkg::QUEUE_DEPTH);
   assign p_full = pend_count_ff == teq_pkg::pcnt_type'(teq_pkg::PEND_DEPTH);

   always_comb begin
      q_cmd           = teq_pkg::CMD_HOLD;
      p_cmd           = teq_pkg::CMD_HOLD;
      pop_all         = 1'b0;
      q_new           = '0;
      p_new           = q_pick;
      status_in       = teq_pkg::STATUS_OK;
      shown_in        = '0;
      event_count_in  = event_count_ff;
      pend_count_in   = pend_count_ff;
      current_time_in = current_time_ff;
      executed_in     = executed_ff;
      case (teq_pkg::kind_type'(item_kind_ff))
         teq_pkg::KIND_INSERT: begin
            q_new.ev_time = item_time_ff;
            q_new.node    = item_node_ff;
            q_new.handle  = item_handle_ff;
            q_new.prio    = item_prio_ff;
            if (q_full) begin
               status_in = teq_pkg::STATUS_FULL;
            end else begin
               q_cmd          = teq_pkg::CMD_INSERT;
               event_count_in = event_count_ff + teq_pkg::qcnt_type'(1);
            end
         end
         teq_pkg::KIND_POP: begin
            if (event_count_ff == '0) begin
               status_in = teq_pkg::STATUS_EMPTY;
            end else begin
               shown_in = q_entry[0];
               if (current_time_ff > time_limit) begin
                  status_in = teq_pkg::STATUS_STOP;
               end else begin
                  q_cmd           = teq_pkg::CMD_REMOVE;
                  pop_all         = 1'b1;
                  event_count_in  = event_count_ff - teq_pkg::qcnt_type'(1);
                  current_time_in = q_entry[0].ev_time;
                  executed_in     = executed_ff + teq_pkg::total_type'(1);
               end
            end
         end
         teq_pkg::KIND_PEND: begin
            if (q_match == '0) begin
               status_in = teq_pkg::STATUS_NOMATCH;
            end else if (p_full) begin
               status_in = teq_pkg::STATUS_FULL;
            end else begin
               q_cmd          = teq_pkg::CMD_REMOVE;
               p_cmd          = teq_pkg::CMD_APPEND;
               event_count_in = event_count_ff - teq_pkg::qcnt_type'(1);
               pend_count_in  = pend_count_ff + teq_pkg::pcnt_type'(1);
            end
         end
         teq_pkg::KIND_UPGRADE: begin
            q_new.ev_time = item_time_ff;
            q_new.node    = item_node_ff;
            q_new.handle  = p_pick.handle;
            q_new.prio    = 1'b0;
            if (p_match == '0) begin
               status_in = teq_pkg::STATUS_NOMATCH;
            end else if (q_full) begin
               status_in = teq_pkg::STATUS_FULL;
            end else begin
               q_cmd          = teq_pkg::CMD_INSERT;
               p_cmd          = teq_pkg::CMD_REMOVE;
               event_count_in = event_count_ff + teq_pkg::qcnt_type'(1);
               pend_count_in  = pend_count_ff - teq_pkg::pcnt_type'(1);
            end
         end
         default: begin
            status_in = teq_pkg::STATUS_NOMATCH;
         end
      endcase
      if (!commit) begin
         q_cmd           = teq_pkg::CMD_HOLD;
         p_cmd           = teq_pkg::CMD_HOLD;
         event_count_in  = event_count_ff;
         pend_count_in   = pend_count_ff;
         current_time_in = current_time_ff;
         executed_in     = executed_ff;
      end
   end

   always_comb begin
      case (state_ff)
         STATE_IDLE:  state_in = accept ? STATE_APPLY : STATE_IDLE;
         STATE_APPLY: state_in = commit ? STATE_IDLE : STATE_APPLY;
         default:     state_in = STATE_IDLE;
      endcase
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= STATE_IDLE;
         event_count_ff  <= '0;
         pend_count_ff   <= '0;
         current_time_ff <= '0;
         executed_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         event_count_ff  <= event_count_in;
         pend_count_ff   <= pend_count_in;
         current_time_ff <= current_time_in;
         executed_ff     <= executed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_kind_ff   <= req_ch.kind;
         item_time_ff   <= req_ch.event_time;
         item_node_ff   <= req_ch.node_id;
         item_handle_ff <= teq_pkg::handle_type'(req_ch.handle_tag);
         item_prio_ff   <= req_ch.hi_prio;
      end
      if (commit) begin
         rsp_status_ff <= status_in;
         rsp_entry_ff  <= shown_in;
         rsp_count_ff  <= event_count_in;
         rsp_total_ff  <= executed_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.out_time       = rsp_entry_ff.ev_time;
   assign rsp_ch.out_node       = rsp_entry_ff.node;
   assign rsp_ch.out_handle     = teq_pkg::tag_type'(rsp_entry_ff.handle);
   assign rsp_ch.out_priority   = rsp_entry_ff.prio;
   assign rsp_ch.queue_count    = teq_pkg::qout_type'(rsp_count_ff);
   assign rsp_ch.executed_total = rsp_total_ff;

   `TEQ_ASSERT(a_qcount_bound, clock, reset, event_count_ff <= teq_pkg::qcnt_type'(teq_pkg::QUEUE_DEPTH))
   `TEQ_ASSERT(a_pcount_bound, clock, reset, pend_count_ff <= teq_pkg::pcnt_type'(teq_pkg::PEND_DEPTH))
   `TEQ_ASSERT(a_first_onehot, clock, reset, $onehot0(q_first))
   `TEQ_ASSERT_NEXT(a_count_hold, clock, reset, !commit, $stable(event_count_ff))
   `TEQ_ASSERT_NEXT(a_exec_hold, clock, reset, !(commit && item_kind_ff == teq_pkg::KIND_POP), $stable(executed_ff))

endmodule

### src/teq_cell.sv
module teq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  teq_pkg::cell_ctl_type ctl,
   input  logic                  occ,
   input  logic                  occ_left,
   input  logic                  gt_left,
   input  logic                  remove_here,
   input  teq_pkg::entry_type    left_entry,
   input  teq_pkg::entry_type    right_entry,
   output teq_pkg::entry_type    entry,
   output logic                  gt,
   output logic                  match
);

   teq_pkg::entry_type entry_ff, entry_in;
   logic               gt_ff, gt_in;
   logic               match_ff, match_in;
   logic               first_empty;

   assign first_empty = !occ && occ_left;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.cmd)
         teq_pkg::CMD_INSERT: begin
            if (gt_left) begin
               entry_in = left_entry;
            end else if (gt_ff || first_empty) begin
               entry_in = ctl.new_entry;
            end
         end
         teq_pkg::CMD_APPEND: begin
            if (first_empty) begin
               entry_in = ctl.new_entry;
            end
         end
         teq_pkg::CMD_REMOVE: begin
            if (remove_here) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_comb begin
      gt_in    = gt_ff;
      match_in = match_ff;
      if (ctl.load_flags) begin
         gt_in    = occ && (entry_ff.ev_time > ctl.key_time);
         match_in = occ && (entry_ff.node == ctl.key_node)
                    && (!ctl.low_only || !entry_ff.prio);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         gt_ff    <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         gt_ff    <= gt_in;
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign gt    = gt_ff;
   assign match = match_ff;

endmodule

### src/teq_csr.sv
module teq_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  teq_pkg::apb_req_type  apb,
   output teq_pkg::csr_data_type prdata,
   output logic                  pready,
   output teq_pkg::time_type     time_limit
);

   teq_pkg::time_type time_limit_ff, time_limit_in;
   logic              hit;

   assign hit = apb.paddr[teq_pkg::CSR_ADDR_W-1:2] == teq_pkg::REG_TIME_LIMIT;

   always_comb begin
      time_limit_in = time_limit_ff;
      if (apb.psel && apb.penable && apb.pwrite && hit) begin
         time_limit_in = apb.pwdata[teq_pkg::TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_limit_ff <= teq_pkg::TIME_LIMIT_RESET;
      end else begin
         time_limit_ff <= time_limit_in;
      end
   end

   assign prdata     = hit ? teq_pkg::csr_data_type'(time_limit_ff) : '0;
   assign pready     = 1'b1;
   assign time_limit = time_limit_ff;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 13;
   localparam int PHASE_ITEMS = 80;

   typedef enum int {MIX_FILL, MIX_PARK, MIX_CHURN, MIX_DRAIN} mix_type;

   typedef struct {
      teq_pkg::kind_type kind;
      teq_pkg::time_type event_time;
      teq_pkg::node_type node_id;
      teq_pkg::tag_type  handle_tag;
      logic              hi_prio;
   } order_type;

   typedef struct {
      teq_pkg::status_type status;
      teq_pkg::time_type   out_time;
      teq_pkg::node_type   out_node;
      teq_pkg::tag_type    out_handle;
      logic                out_priority;
      teq_pkg::qout_type   queue_count;
      teq_pkg::total_type  executed_total;
   } outcome_type;

   typedef struct {
      bit                set_limit;
      teq_pkg::time_type limit;
      order_type         op;
      bit                pinned;
      outcome_type       want;
   } step_type;

   logic clock = 1'b0;
   logic reset;

   teq_req_if req_ch ();
   teq_rsp_if rsp_ch ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   teq_pkg::csr_addr_type csr_paddr;
   teq_pkg::csr_data_type csr_pwdata;
   teq_pkg::csr_data_type csr_prdata;
   logic                  csr_pready;

   logic        row_pinned;
   outcome_type row_want;

   teq_pkg::entry_type sched_q[$];
   teq_pkg::entry_type parked_q[$];
   teq_pkg::time_type  now_time;
   teq_pkg::total_type done_total;
   teq_pkg::time_type  limit_model;

   outcome_type outcomes_due[$];
   step_type    script[$];

   int failures;
   int items_taken;
   int responses_checked;
   int cycles;
   int status_hits[5];
   bit tx_calm;

   timed_event_queue_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic outcome_type bare(teq_pkg::status_type s, teq_pkg::qout_type q,
                                        teq_pkg::total_type tot);
      outcome_type o;
      o.status = s;
      o.out_time = '0;
      o.out_node = '0;
      o.out_handle = '0;
      o.out_priority = 1'b0;
      o.queue_count = q;
      o.executed_total = tot;
      return o;
   endfunction

   function automatic void put_event(teq_pkg::entry_type e);
      int pos = 0;
      while (pos < sched_q.size() && sched_q[pos].ev_time <= e.ev_time) pos++;
      sched_q.insert(pos, e);
   endfunction

   function automatic outcome_type queue_outcome(order_type r);
      outcome_type        o;
      teq_pkg::entry_type e;
      o = bare(teq_pkg::STATUS_OK, '0, '0);
      case (r.kind)
         teq_pkg::KIND_INSERT: begin
            e.ev_time = r.event_time;
            e.node = r.node_id;
            e.handle = teq_pkg::handle_type'(r.handle_tag);
            e.prio = r.hi_prio;
            if (sched_q.size() >= teq_pkg::QUEUE_DEPTH) o.status = teq_pkg::STATUS_FULL;
            else put_event(e);
         end
         teq_pkg::KIND_POP: begin
            if (sched_q.size() == 0) begin
               o.status = teq_pkg::STATUS_EMPTY;
            end else begin
               e = sched_q[0];
               o.out_time = e.ev_time;
               o.out_node = e.node;
               o.out_handle = teq_pkg::tag_type'(e.handle);
               o.out_priority = e.prio;
               if (now_time > limit_model) begin
                  o.status = teq_pkg::STATUS_STOP;
               end else begin
                  now_time = e.ev_time;
                  void'(sched_q.pop_front());
                  done_total++;
               end
            end
         end
         teq_pkg::KIND_PEND: begin
            o.status = teq_pkg::STATUS_NOMATCH;
            for (int i = 0; i < sched_q.size(); i++) begin
               if (sched_q[i].node == r.node_id && sched_q[i].prio == 1'b0) begin
                  if (parked_q.size() >= teq_pkg::PEND_DEPTH) begin
                     o.status = teq_pkg::STATUS_FULL;
                  end else begin
                     parked_q.insert(parked_q.size(), sched_q[i]);
                     sched_q.delete(i);
                     o.status = teq_pkg::STATUS_OK;
                  end
                  break;
               end
            end
         end
         default: begin
            o.status = teq_pkg::STATUS_NOMATCH;
            for (int i = 0; i < parked_q.size(); i++) begin
               if (parked_q[i].node == r.node_id) begin
                  e.ev_time = r.event_time;
                  e.node = r.node_id;
                  e.handle = parked_q[i].handle;
                  e.prio = 1'b0;
                  if (sched_q.size() >= teq_pkg::QUEUE_DEPTH) begin
                     o.status = teq_pkg::STATUS_FULL;
                  end else begin
                     put_event(e);
                     parked_q.delete(i);
                     o.status = teq_pkg::STATUS_OK;
                  end
                  break;
               end
            end
         end
      endcase
      o.queue_count = teq_pkg::qout_type'(sched_q.size());
      o.executed_total = done_total;
      return o;
   endfunction

   function automatic void row(teq_pkg::kind_type k, teq_pkg::time_type t,
                               teq_pkg::node_type n, teq_pkg::tag_type h, logic p);
      step_type s;
      s.set_limit = 1'b0;
      s.limit = '0;
      s.op.kind = k;
      s.op.event_time = t;
      s.op.node_id = n;
      s.op.handle_tag = h;
      s.op.hi_prio = p;
      s.pinned = 1'b0;
      s.want = bare(teq_pkg::STATUS_OK, '0, '0);
      script.insert(script.size(), s);
   endfunction

   function automatic void pin(teq_pkg::kind_type k, teq_pkg::time_type t,
                               teq_pkg::node_type n, teq_pkg::tag_type h, logic p,
                               teq_pkg::status_type st, teq_pkg::qout_type q,
                               teq_pkg::total_type tot);
      row(k, t, n, h, p);
      script[script.size() - 1].pinned = 1'b1;
      script[script.size() - 1].want = bare(st, q, tot);
   endfunction

   function automatic void limit_row(teq_pkg::time_type v);
      row(teq_pkg::KIND_POP, '0, '0, '0, 1'b0);
      script[script.size() - 1].set_limit = 1'b1;
      script[script.size() - 1].limit = v;
   endfunction

   function automatic teq_pkg::time_type pick_time();
      if ($urandom_range(0, 3) == 0) return teq_pkg::time_type'($urandom);
      return teq_pkg::time_type'($urandom_range(0, 4000));
   endfunction

   function automatic order_type random_order(mix_type mix);
      order_type r;
      int roll;
      int w_ins, w_pop, w_pend;
      case (mix)
         MIX_FILL:  begin w_ins = 60; w_pop = 10; w_pend = 20; end
         MIX_PARK:  begin w_ins = 35; w_pop = 10; w_pend = 45; end
         MIX_CHURN: begin w_ins = 30; w_pop = 30; w_pend = 20; end
         default:   begin w_ins = 10; w_pop = 70; w_pend = 10; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < w_ins) r.kind = teq_pkg::KIND_INSERT;
      else if (roll < w_ins + w_pop) r.kind = teq_pkg::KIND_POP;
      else if (roll < w_ins + w_pop + w_pend) r.kind = teq_pkg::KIND_PEND;
      else r.kind = teq_pkg::KIND_UPGRADE;
      r.event_time = pick_time();
      if ($urandom_range(0, 99) < 85) r.node_id = teq_pkg::node_type'($urandom_range(0, 7));
      else r.node_id = teq_pkg::node_type'($urandom_range(0, 1023));
      r.handle_tag = teq_pkg::tag_type'($urandom_range(0, 65535));
      r.hi_prio = ($urandom_range(0, 99) < 40);
      return r;
   endfunction

   function automatic void match_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   task automatic offer(order_type r, bit pinned, outcome_type want);
      int gap;
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= r.kind;
      req_ch.event_time <= r.event_time;
      req_ch.node_id <= r.node_id;
      req_ch.handle_tag <= r.handle_tag;
      req_ch.hi_prio <= r.hi_prio;
      row_pinned <= pinned;
      row_want <= want;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outcomes_due.size() != 0);
   endtask

   task automatic program_limit(teq_pkg::time_type v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {teq_pkg::REG_TIME_LIMIT, 2'b00};
      csr_pwdata <= {1'b0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      limit_model = v;
   endtask

   always @(posedge clock) begin : scoreboard
      order_type   r;
      outcome_type o;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            r.kind = teq_pkg::kind_type'(req_ch.kind);
            r.event_time = req_ch.event_time;
            r.node_id = req_ch.node_id;
            r.handle_tag = req_ch.handle_tag;
            r.hi_prio = req_ch.hi_prio;
            o = queue_outcome(r);
            if (row_pinned) o = row_want;
            outcomes_due.insert(outcomes_due.size(), o);
            items_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcomes_due.size() == 0) begin
               $error("response transfer with no request outstanding");
               failures++;
            end else begin
               o = outcomes_due.pop_front();
               match_field("status", o.status, rsp_ch.status);
               match_field("out_time", o.out_time, rsp_ch.out_time);
               match_field("out_node", o.out_node, rsp_ch.out_node);
               match_field("out_handle", o.out_handle, rsp_ch.out_handle);
               match_field("out_priority", o.out_priority, rsp_ch.out_priority);
               match_field("queue_count", o.queue_count, rsp_ch.queue_count);
               match_field("executed_total", o.executed_total, rsp_ch.executed_total);
               status_hits[int'(o.status)]++;
               responses_checked++;
            end
         end
      end
   end

   initial begin : rsp_sink
      int gap;
      int seen;
      bit calm;
      seen = 0;
      calm = 1'b0;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen++;
            if ($urandom_range(0, 31) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 8);
            // A long hold-off lets the queue back up until the request side stalls.
            if (seen == 300) gap = 150;
            if (gap != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   initial begin : stimulus
      teq_pkg::time_type lim;
      mix_type           mix;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = teq_pkg::KIND_INSERT;
      req_ch.event_time = '0;
      req_ch.node_id = '0;
      req_ch.handle_tag = '0;
      req_ch.hi_prio = 1'b0;
      row_pinned = 1'b0;
      row_want = bare(teq_pkg::STATUS_OK, '0, '0);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      now_time = '0;
      done_total = '0;
      limit_model = teq_pkg::TIME_LIMIT_RESET;
      tx_calm = 1'b0;

      pin(teq_pkg::KIND_POP, '0, '0, '0, 1'b0, teq_pkg::STATUS_EMPTY, 7'd0, 32'd0);
      pin(teq_pkg::KIND_PEND, '0, 10'd5, '0, 1'b0, teq_pkg::STATUS_NOMATCH, 7'd0, 32'd0);
      pin(teq_pkg::KIND_UPGRADE, 31'd9, 10'd5, '0, 1'b0,
          teq_pkg::STATUS_NOMATCH, 7'd0, 32'd0);
      pin(teq_pkg::KIND_INSERT, '1, '1, '1, 1'b1, teq_pkg::STATUS_OK, 7'd1, 32'd0);
      pin(teq_pkg::KIND_INSERT, '0, '0, '0, 1'b0, teq_pkg::STATUS_OK, 7'd2, 32'd0);
      pin(teq_pkg::KIND_INSERT, 31'd100, 10'd7, 16'h1234, 1'b0,
          teq_pkg::STATUS_OK, 7'd3, 32'd0);
      pin(teq_pkg::KIND_INSERT, 31'd100, 10'd7, 16'h5678, 1'b0,
          teq_pkg::STATUS_OK, 7'd4, 32'd0);
      pin(teq_pkg::KIND_INSERT, 31'd100, 10'd8, 16'h9abc, 1'b1,
          teq_pkg::STATUS_OK, 7'd5, 32'd0);
      pin(teq_pkg::KIND_PEND, '0, 10'd7, '0, 1'b0, teq_pkg::STATUS_OK, 7'd4, 32'd0);
      pin(teq_pkg::KIND_PEND, '0, 10'd8, '0, 1'b0, teq_pkg::STATUS_NOMATCH, 7'd4, 32'd0);
      pin(teq_pkg::KIND_UPGRADE, 31'd100, 10'd7, '0, 1'b0,
          teq_pkg::STATUS_OK, 7'd5, 32'd0);
      row(teq_pkg::KIND_POP, '0, '0, '0, 1'b0);
      row(teq_pkg::KIND_POP, '0, '0, '0, 1'b0);
      row(teq_pkg::KIND_POP, '0, '0, '0, 1'b0);
      row(teq_pkg::KIND_POP, '0, '0, '0, 1'b0);
      row(teq_pkg::KIND_POP, '0, '0, '0, 1'b0);
      pin(teq_pkg::KIND_INSERT, 31'd50, 10'd2, 16'haaaa, 1'b0,
          teq_pkg::STATUS_OK, 7'd1, 32'd5);
      limit_row('0);
      row(teq_pkg::KIND_POP, '0, '0, '0, 1'b0);
      pin(teq_pkg::KIND_PEND, '0, 10'd2, '0, 1'b0, teq_pkg::STATUS_OK, 7'd0, 32'd5);
      pin(teq_pkg::KIND_UPGRADE, '0, 10'd2, '0, 1'b0, teq_pkg::STATUS_OK, 7'd1, 32'd5);
      limit_row('1);
      row(teq_pkg::KIND_POP, '0, '0, '0, 1'b0);
      pin(teq_pkg::KIND_POP, '0, '0, '0, 1'b0, teq_pkg::STATUS_EMPTY, 7'd0, 32'd6);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].set_limit) begin
            settle();
            program_limit(script[i].limit);
         end else begin
            offer(script[i].op, script[i].pinned, script[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 3))
            0: lim = '0;
            1: lim = '1;
            2: lim = teq_pkg::time_type'($urandom_range(0, 4000));
            default: lim = teq_pkg::time_type'($urandom);
         endcase
         case (p % 6)
            0, 1, 3: mix = MIX_FILL;
            2: mix = MIX_PARK;
            4: mix = MIX_CHURN;
            default: mix = MIX_DRAIN;
         endcase
         settle();
         program_limit(lim);
         repeat (PHASE_ITEMS) offer(random_order(mix), 1'b0, bare(teq_pkg::STATUS_OK, '0, '0));
      end

      settle();
      repeat (10) @(posedge clock);
      $display("Ran %0d operations through the queue, %0d responses compared.",
               items_taken, responses_checked);
      $display("Responses seen: ok %0d, empty %0d, full %0d, no match %0d, stop %0d.",
               status_hits[teq_pkg::STATUS_OK], status_hits[teq_pkg::STATUS_EMPTY],
               status_hits[teq_pkg::STATUS_FULL], status_hits[teq_pkg::STATUS_NOMATCH],
               status_hits[teq_pkg::STATUS_STOP]);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/teq_pkg.sv
src/teq_req_if.sv
src/teq_rsp_if.sv
src/teq_cell.sv
src/teq_csr.sv
src/timed_event_queue_top.sv
dv/testbench.sv
